// ----- rtl/bfba_pkg.sv -----
// Package for the best-fit block allocator.
// Holds the result status codes and the structs passed along the cell chain.
// No dependencies.
package bfba_pkg;

    // Widest block size and block index that the chain structs carry.
    localparam int SIZE_W = 32;
    localparam int IDX_W  = 8;

    // Item kinds.
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_ADDED = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] size;
    } cand_t;

    // Write broadcast from the controller to every cell.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] data;
    } wr_t;

endpackage

// ----- rtl/bfba_if.sv -----
// Handshake interfaces for the best-fit block allocator channels.
// Request items in, result items out; no dependencies.
interface bfba_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [23:0] amount;

    modport source (output valid, output req_type, output amount, input ready);
    modport sink   (input valid, input req_type, input amount, output ready);
endinterface

interface bfba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  block_number;
    logic [23:0] remaining_size;

    modport source (output valid, output status, output block_number,
                    output remaining_size, input ready);
    modport sink   (input valid, input status, input block_number,
                    input remaining_size, output ready);
endinterface

// ----- rtl/best_fit_block_allocator.sv -----
// Best-fit block allocator: an add item goes from acceptance straight to the DONE
// state; an allocate item first waits in SCAN while the search token walks the
// chain of MAX_BLOCKS cells, one cell per cycle.
// One item is worked on at a time; the result register lets the next item be
// accepted while a result still waits. Reset (rst_n, async, active low) empties
// the table; block sizes are not cleared and are read only after being written.
module best_fit_block_allocator #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    bfba_req_if.sink          req,
    bfba_rsp_if.source        rsp
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SZ_W  = bfba_pkg::SIZE_W;
    localparam int IX_W  = bfba_pkg::IDX_W;

    // Controller states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic                 inj_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 type_reg;
    logic [SIZE_BITS-1:0] amt_reg;
    logic                 found_reg;
    logic [IX_W-1:0]      best_idx_reg;
    logic [SIZE_BITS-1:0] best_size_reg;

    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic [3:0]           block_number_reg;
    logic [23:0]          remaining_size_reg;

    logic                 slot_free;
    logic                 finish;
    logic                 full;
    logic [SIZE_BITS-1:0] new_size;
    logic [1:0]           status_next;
    logic [IX_W-1:0]      num_next;
    logic [SIZE_BITS-1:0] rem_next;

    bfba_pkg::cand_t      cand_w [0:MAX_BLOCKS];
    bfba_pkg::wr_t        wr;

    // The request side is open whenever no item is in progress; the result
    // register decouples it from the downstream consumer.
    assign req.ready = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || rsp.ready;
    assign finish    = (state_reg == S_DONE) && slot_free;
    assign full      = (count_reg == CNT_W'(MAX_BLOCKS));
    assign new_size  = best_size_reg - amt_reg;

    // The search token enters the first cell in the cycle after an allocate is
    // accepted and leaves the last cell after passing through every cell's register.
    assign cand_w[0] = '{valid: inj_reg, found: 1'b0, idx: '0, size: '0};

    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_cell
        bfba_cell #(
            .IDX        (g),
            .MAX_BLOCKS (MAX_BLOCKS),
            .SIZE_BITS  (SIZE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cand_in  (cand_w[g]),
            .amt      (amt_reg),
            .count    (count_reg),
            .wr       (wr),
            .cand_out (cand_w[g+1])
        );
    end

    // Result selection and the write that updates the table when the result
    // is committed: an add writes the next free cell, an allocate writes the
    // reduced size back into the winning cell.
    always_comb
    begin
        wr.en       = 1'b0;
        wr.idx      = '0;
        wr.data     = '0;
        status_next = bfba_pkg::ST_NOFIT;
        num_next    = '0;
        rem_next    = '0;
        if (type_reg == bfba_pkg::REQ_ADD)
        begin
            if (full)
            begin
                status_next = bfba_pkg::ST_FULL;
            end
            else
            begin
                status_next = bfba_pkg::ST_ADDED;
                num_next    = IX_W'(count_reg);
                rem_next    = amt_reg;
                wr.en       = finish;
                wr.idx      = IX_W'(count_reg);
                wr.data     = SZ_W'(amt_reg);
            end
        end
        else if (found_reg)
        begin
            status_next = bfba_pkg::ST_ALLOC;
            num_next    = best_idx_reg;
            rem_next    = new_size;
            wr.en       = finish;
            wr.idx      = best_idx_reg;
            wr.data     = SZ_W'(new_size);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.req_type == bfba_pkg::REQ_ALLOC) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (cand_w[MAX_BLOCKS].valid)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            inj_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            inj_reg   <= req.valid && req.ready && (req.req_type == bfba_pkg::REQ_ALLOC);
            if (finish && type_reg == bfba_pkg::REQ_ADD && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            type_reg <= req.req_type;
            amt_reg  <= SIZE_BITS'(req.amount);
        end
        if (state_reg == S_SCAN && cand_w[MAX_BLOCKS].valid)
        begin
            found_reg     <= cand_w[MAX_BLOCKS].found;
            best_idx_reg  <= cand_w[MAX_BLOCKS].idx;
            best_size_reg <= cand_w[MAX_BLOCKS].size[SIZE_BITS-1:0];
        end
        if (finish)
        begin
            status_reg         <= status_next;
            block_number_reg   <= 4'(num_next);
            remaining_size_reg <= 24'(rem_next);
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.block_number   = block_number_reg;
    assign rsp.remaining_size = remaining_size_reg;

`ifndef SYNTHESIS
    // The table never holds more blocks than there are cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count exceeds table size");

    // A token leaves the chain only while the controller waits for it.
    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cand_w[MAX_BLOCKS].valid |-> state_reg == S_SCAN)
        else $error("search token left the chain outside a scan");

    // An accepted item always puts the controller to work.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> state_reg != S_IDLE)
        else $error("accepted item left the controller idle");

    // A new result appears only as an item completes.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised without a completing item");
`endif

endmodule

// ----- rtl/bfba_cell.sv -----
// One cell of the allocator chain: stores one block size and refines the
// passing best-fit search token. Depends on bfba_pkg.
module bfba_cell #(
    parameter int IDX        = 0,
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bfba_pkg::cand_t                cand_in,
    input  logic [SIZE_BITS-1:0]           amt,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0] count,
    input  bfba_pkg::wr_t                  wr,
    output bfba_pkg::cand_t                cand_out
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SZ_W  = bfba_pkg::SIZE_W;
    localparam int IX_W  = bfba_pkg::IDX_W;

    logic [SIZE_BITS-1:0] size_reg;
    bfba_pkg::cand_t      cand_next;
    bfba_pkg::cand_t      cand_reg;
    logic                 active;
    logic                 better;

    // The cell takes part only once its block has been added.
    assign active = count > CNT_W'(IDX);
    assign better = active && (size_reg >= amt)
                    && (!cand_in.found || size_reg < cand_in.size[SIZE_BITS-1:0]);

    always_comb
    begin
        cand_next = cand_in;
        if (cand_in.valid && better)
        begin
            cand_next.found = 1'b1;
            cand_next.idx   = IX_W'(IDX);
            cand_next.size  = SZ_W'(size_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.idx == IX_W'(IDX))
        begin
            size_reg <= wr.data[SIZE_BITS-1:0];
        end
    end

    assign cand_out = cand_reg;

endmodule
